>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define HLTM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds while reset is released.
`define HLTM_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/hltm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hltm_pkg;

    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_COMMA = 8'h2C;

    // Size of the token register store in bytes.
    localparam int STORE_BYTES = 16;
    localparam int STORE_IDX_W = $clog2(STORE_BYTES);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int TLEN_W      = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOKEN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOKEN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOKEN_LEN  = 2'd2;

    typedef struct packed {
        logic valid;
        logic found;
    } t_scan_result;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hltm_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module hltm_scan #(
    parameter int MAX_TOKEN_BYTES = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_take,
    input  wire logic [7:0]                      i_value_byte,
    input  wire logic                            i_last_byte,
    input  wire logic [hltm_pkg::CFG_DATA_W-1:0] i_token_low,
    input  wire logic [hltm_pkg::CFG_DATA_W-1:0] i_token_high,
    input  wire logic [hltm_pkg::TLEN_W-1:0]     i_token_length,
    output hltm_pkg::t_scan_result               o_result
);

    localparam int CW = $clog2(MAX_TOKEN_BYTES + 2);
    localparam int PW = (CW > hltm_pkg::STORE_IDX_W) ? CW : hltm_pkg::STORE_IDX_W;
    localparam int LW = (CW > hltm_pkg::TLEN_W) ? CW : hltm_pkg::TLEN_W;
    localparam logic [CW-1:0] SAT = CW'(MAX_TOKEN_BYTES + 1);

    logic          r_in_part, n_in_part;
    logic [CW-1:0] r_count, n_count;
    logic          r_run_ok, n_run_ok;
    logic [CW-1:0] r_trim_len, n_trim_len;
    logic          r_trim_ok, n_trim_ok;
    logic          r_found, n_found;

    logic [7:0] w_tok [hltm_pkg::STORE_BYTES];
    logic       w_blank, w_comma, w_take_byte, w_pos_ok, w_match;
    logic [hltm_pkg::STORE_IDX_W-1:0] w_idx;
    logic [PW-1:0] w_pos_ext;
    logic [CW-1:0] w_count_inc;
    logic       w_run_new;
    logic       w_len_ok;
    logic       w_end_cur, w_end_post;

    genvar g;
    generate
        for (g = 0; g < hltm_pkg::STORE_BYTES / 2; g++) begin : g_tok
            assign w_tok[g]                            = i_token_low[8*g +: 8];
            assign w_tok[g + hltm_pkg::STORE_BYTES/2]  = i_token_high[8*g +: 8];
        end
    endgenerate

    assign w_blank     = (i_value_byte == hltm_pkg::C_SPACE) || (i_value_byte == hltm_pkg::C_TAB);
    assign w_comma     = (i_value_byte == hltm_pkg::C_COMMA);
    assign w_take_byte = r_in_part ? !w_comma : (!w_blank && !w_comma);

    assign w_pos_ok  = (32'(r_count) < MAX_TOKEN_BYTES) && (32'(r_count) < hltm_pkg::STORE_BYTES);
    assign w_pos_ext = PW'(r_count);
    assign w_idx     = w_pos_ext[hltm_pkg::STORE_IDX_W-1:0];
    assign w_match   = w_pos_ok &&
                       (hltm_pkg::fold(i_value_byte) == hltm_pkg::fold(w_tok[w_idx]));
    assign w_run_new = r_run_ok && w_match;
    assign w_count_inc = (r_count == SAT) ? r_count : r_count + CW'(1);

    // Length rule shared by both places where an element can end.
    assign w_len_ok = (i_token_length != '0) &&
                      (32'(i_token_length) <= MAX_TOKEN_BYTES) &&
                      (32'(i_token_length) <= hltm_pkg::STORE_BYTES);

    assign w_end_cur  = r_in_part && r_trim_ok && w_len_ok &&
                        (LW'(r_trim_len) == LW'(i_token_length));

    always_comb begin
        // While no element is open the per-element state already holds its
        // cleared values, so a new element continues from the registers.
        n_in_part  = r_in_part;
        n_count    = r_count;
        n_run_ok   = r_run_ok;
        n_trim_len = r_trim_len;
        n_trim_ok  = r_trim_ok;
        n_found    = r_found;
        if (w_take_byte) begin
            n_in_part = 1'b1;
            n_count   = w_count_inc;
            n_run_ok  = w_run_new;
            if (!w_blank) begin
                n_trim_len = w_count_inc;
                n_trim_ok  = w_run_new;
            end
        end else if (r_in_part) begin
            n_found    = r_found || w_end_cur;
            n_in_part  = 1'b0;
            n_count    = '0;
            n_run_ok   = 1'b1;
            n_trim_len = '0;
            n_trim_ok  = 1'b0;
        end
    end

    assign w_end_post = n_in_part && n_trim_ok && w_len_ok &&
                        (LW'(n_trim_len) == LW'(i_token_length));

    always_comb begin
        o_result.valid = i_take && i_last_byte;
        o_result.found = n_found || w_end_post;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_part  <= 1'b0;
            r_count    <= '0;
            r_run_ok   <= 1'b1;
            r_trim_len <= '0;
            r_trim_ok  <= 1'b0;
            r_found    <= 1'b0;
        end else if (i_take) begin
            if (i_last_byte) begin
                r_in_part  <= 1'b0;
                r_count    <= '0;
                r_run_ok   <= 1'b1;
                r_trim_len <= '0;
                r_trim_ok  <= 1'b0;
                r_found    <= 1'b0;
            end else begin
                r_in_part  <= n_in_part;
                r_count    <= n_count;
                r_run_ok   <= n_run_ok;
                r_trim_len <= n_trim_len;
                r_trim_ok  <= n_trim_ok;
                r_found    <= n_found;
            end
        end
    end

`include "assert_macros.svh"

    `HLTM_NEVER(a_idle_state_clear, i_clk, i_rst_n, !r_in_part && (r_count != '0 || !r_run_ok || r_trim_ok), "per-element state not cleared outside an element")
    `HLTM_ASSERT(a_trim_le_count, i_clk, i_rst_n, r_trim_len <= r_count, "trimmed length exceeds element length")
    `HLTM_ASSERT(a_last_clears, i_clk, i_rst_n, i_take && i_last_byte |=> !r_found && !r_in_part, "string state survives its last byte")

endmodule

`default_nettype wire

>>> rtl/header_list_token_match.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_value_byte, i_last_byte
// result    out        o_out_valid / i_out_stall  o_token_found
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One byte is taken every cycle unless stalled; the match logic sits between the
// element state registers and a two-entry result queue (output register plus
// skid). A result is registered (output register or skid) when its last byte
// is taken. Input stalls only when both result entries are full.
// Reset is synchronous, active low, and clears the token registers to zero.

module header_list_token_match #(
    parameter int MAX_TOKEN_BYTES = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [7:0]                       i_value_byte,
    input  wire logic                             i_last_byte,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_token_found,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [hltm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [hltm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [hltm_pkg::CFG_DATA_W-1:0] r_token_low;
    logic [hltm_pkg::CFG_DATA_W-1:0] r_token_high;
    logic [hltm_pkg::TLEN_W-1:0]     r_token_length;

    logic r_out_valid, r_out_found;
    logic r_skid_valid, r_skid_found;

    logic                   w_take;
    logic                   w_pop;
    hltm_pkg::t_scan_result w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_low    <= '0;
            r_token_high   <= '0;
            r_token_length <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hltm_pkg::CFG_TOKEN_LOW:  r_token_low    <= i_cfg_data;
                hltm_pkg::CFG_TOKEN_HIGH: r_token_high   <= i_cfg_data;
                hltm_pkg::CFG_TOKEN_LEN:  r_token_length <= i_cfg_data[hltm_pkg::TLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = r_skid_valid;
    assign w_take     = i_in_valid && !r_skid_valid;
    assign w_pop      = r_out_valid && !i_out_stall;

    hltm_scan #(
        .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_take),
        .i_value_byte   (i_value_byte),
        .i_last_byte    (i_last_byte),
        .i_token_low    (r_token_low),
        .i_token_high   (r_token_high),
        .i_token_length (r_token_length),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_pop) begin
                // The skid entry is older than a new result and goes first.
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= w_result.valid;
                end else begin
                    r_out_valid  <= w_result.valid;
                end
            end else if (w_result.valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_found  <= r_skid_found;
                r_skid_found <= w_result.found;
            end else begin
                r_out_found  <= w_result.found;
            end
        end else if (w_result.valid) begin
            r_skid_found <= w_result.found;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_token_found = r_out_found;

`include "assert_macros.svh"

    `HLTM_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid entry held with empty output register")
    `HLTM_NEVER(a_no_overflow, i_clk, i_rst_n, w_result.valid && r_skid_valid, "result produced while queue is full")
    `HLTM_ASSERT(a_skid_fill_cause, i_clk, i_rst_n, $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall), "skid filled without a stalled output")

endmodule

`default_nettype wire

>>> sim/tb_header_list_token_match.sv
`timescale 1ns / 1ps

module tb_header_list_token_match;

    localparam int TOKEN_CAP   = 16;
    localparam int SETTLE      = 4;
    localparam int LONG_HOLD   = 400;
    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_last;
    } t_header_byte;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_stall;
    logic [7:0]                            i_value_byte = 8'h00;
    logic                                  i_last_byte = 1'b0;
    logic                                  o_out_valid;
    logic                                  i_out_stall = 1'b0;
    logic                                  o_token_found;
    logic                                  i_cfg_valid = 1'b0;
    logic                                  o_cfg_ready;
    logic [hltm_pkg::CFG_INDEX_W-1:0]      i_cfg_index = '0;
    logic [hltm_pkg::CFG_DATA_W-1:0]       i_cfg_data = '0;

    // Bytes waiting for the driver, and the found flags still owed by the block.
    t_header_byte byte_backlog[$];
    logic         found_owed[$];
    logic [7:0]   value_bytes[$];

    // Token plan used to build stimulus.
    logic [7:0] plan_tok[16];
    int         plan_len;
    int         shape_len;

    // Predictor copy of the registers and of the per-value scan state.
    logic [63:0] tok_low = '0;
    logic [63:0] tok_high = '0;
    logic [4:0]  tok_len = '0;
    bit          elem_open = 1'b0;
    int          elem_len = 0;
    bit          elem_match = 1'b1;
    int          trim_len = 0;
    bit          trim_match = 1'b0;
    bit          value_found = 1'b0;

    int items_queued = 0;
    int items_taken = 0;
    int values_sent = 0;
    int n_hits = 0;
    int n_misses = 0;
    int reg_writes = 0;
    int settings_used = 0;
    int errors = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int hold_left = 0;
    int src_idle_pct = 25;
    int sink_stall_pct = 25;
    int long_holds_asked = 0;
    int long_holds_done = 0;
    int quiet_cycles = 0;

    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    endfunction

    function automatic logic [7:0] vary_case(input logic [7:0] b);
        logic [7:0] low;
        low = b | 8'h20;
        if (low >= 8'h61 && low <= 8'h7A && $urandom_range(1) == 1) return b ^ 8'h20;
        return b;
    endfunction

    function automatic logic [7:0] sep_char(input bit with_comma);
        case ($urandom_range(with_comma ? 2 : 1))
            0: return hltm_pkg::C_SPACE;
            1: return hltm_pkg::C_TAB;
            default: return hltm_pkg::C_COMMA;
        endcase
    endfunction

    task automatic report(input string msg);
        errors++;
        if (errors <= 20) $display("mismatch: %s", msg);
    endtask

    task automatic take_elem_byte(input logic [7:0] c);
        logic [7:0] t;
        if (elem_len >= TOKEN_CAP || elem_len >= hltm_pkg::STORE_BYTES) begin
            elem_match = 1'b0;
        end else begin
            t = (elem_len < 8) ? tok_low[8*elem_len +: 8] : tok_high[8*(elem_len-8) +: 8];
            if (to_lower(c) != to_lower(t)) elem_match = 1'b0;
        end
        if (elem_len < TOKEN_CAP + 1) elem_len++;
        if (c != hltm_pkg::C_SPACE && c != hltm_pkg::C_TAB) begin
            trim_len = elem_len;
            trim_match = elem_match;
        end
    endtask

    task automatic close_elem();
        if (elem_open && trim_match && tok_len != 0 && trim_len == tok_len &&
            tok_len <= TOKEN_CAP && tok_len <= hltm_pkg::STORE_BYTES) begin
            value_found = 1'b1;
        end
        elem_open = 1'b0;
        elem_len = 0;
        elem_match = 1'b1;
        trim_len = 0;
        trim_match = 1'b0;
    endtask

    task automatic track_header_byte(input logic [7:0] c, input logic is_last);
        if (!elem_open) begin
            if (c != hltm_pkg::C_SPACE && c != hltm_pkg::C_TAB && c != hltm_pkg::C_COMMA) begin
                elem_open = 1'b1;
                take_elem_byte(c);
            end
        end else if (c == hltm_pkg::C_COMMA) begin
            close_elem();
        end else begin
            take_elem_byte(c);
        end
        if (is_last) begin
            close_elem();
            found_owed.push_back(value_found);
            if (value_found) n_hits++;
            else n_misses++;
            value_found = 1'b0;
        end
    endtask

    task automatic write_register(input logic [hltm_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic program_token();
        logic [63:0] lo;
        logic [63:0] hi;
        for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = plan_tok[i];
            hi[8*i +: 8] = plan_tok[i+8];
        end
        write_register(hltm_pkg::CFG_TOKEN_LOW, lo);
        write_register(hltm_pkg::CFG_TOKEN_HIGH, hi);
        write_register(hltm_pkg::CFG_TOKEN_LEN, 64'(plan_len));
        settings_used++;
    endtask

    task automatic plan_text(input string s);
        for (int i = 0; i < 16; i++) plan_tok[i] = (i < s.len()) ? s[i] : 8'($urandom);
        shape_len = s.len();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) value_bytes.push_back(s[i]);
    endtask

    task automatic flush_value();
        int n;
        n = value_bytes.size();
        for (int i = 0; i < n; i++) byte_backlog.push_back('{value_bytes[i], i == n - 1});
        items_queued += n;
        values_sent++;
        value_bytes.delete();
    endtask

    // A list of elements built around the planned token: exact copies with mixed case,
    // near misses, overlong elements, empty elements and arbitrary bytes.
    task automatic add_random_value();
        int n_elem;
        int kind;
        int count;
        int pos;
        logic [7:0] b;
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(12, 1)) value_bytes.push_back(8'($urandom));
        end else begin
            n_elem = $urandom_range(4, 1);
            for (int e = 0; e < n_elem; e++) begin
                repeat ($urandom_range(2)) value_bytes.push_back(sep_char(1'b1));
                kind = $urandom_range(9);
                pos = (shape_len > 0) ? $urandom_range(shape_len - 1) : 0;
                count = 0;
                case (kind)
                    0, 1, 2, 3, 4: count = shape_len;
                    5: count = ($urandom_range(1) == 1) ? shape_len - 1 : shape_len + 1;
                    7: count = $urandom_range(20, 17);
                    default: count = 0;
                endcase
                for (int i = 0; i < count; i++) begin
                    b = vary_case(plan_tok[i % 16]);
                    if (kind == 4 && i == pos) b = b ^ 8'h01;
                    value_bytes.push_back(b);
                end
                if (kind == 6) begin
                    repeat ($urandom_range(5, 1)) value_bytes.push_back(8'($urandom));
                end else if (kind == 9) begin
                    repeat ($urandom_range(6, 1))
                        value_bytes.push_back(vary_case(8'h61 + 8'($urandom_range(25))));
                end
                repeat ($urandom_range(2)) value_bytes.push_back(sep_char(1'b0));
                if (e < n_elem - 1) value_bytes.push_back(hltm_pkg::C_COMMA);
            end
        end
        if (value_bytes.size() == 0) value_bytes.push_back(sep_char(1'b1));
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || found_owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n, input int src_pct, input int sink_pct,
                                input bit hold);
        int start;
        start = items_queued;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        while (items_queued - start < n) begin
            add_random_value();
            flush_value();
        end
        // The sink holds off once the whole backlog is queued, so the block backs up.
        if (hold) long_holds_asked++;
        wait_idle();
    endtask

    header_list_token_match #(
        .MAX_TOKEN_BYTES(TOKEN_CAP)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value_byte (i_value_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_token_found(o_token_found),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin : feed
        t_header_byte nxt;
        if (i_rst_n && (!i_in_valid || !o_in_stall)) begin
            if (src_gap > 0) begin
                src_gap--;
                i_in_valid <= 1'b0;
            end else if (byte_backlog.size() == 0) begin
                i_in_valid <= 1'b0;
            end else begin
                nxt = byte_backlog.pop_front();
                i_in_valid <= 1'b1;
                i_value_byte <= nxt.byte_val;
                i_last_byte <= nxt.is_last;
                src_gap = pick_gap(src_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (long_holds_done < long_holds_asked) begin
                hold_left = LONG_HOLD;
                long_holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                sink_gap = pick_gap(sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : watch
        logic want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    hltm_pkg::CFG_TOKEN_LOW:  tok_low = i_cfg_data;
                    hltm_pkg::CFG_TOKEN_HIGH: tok_high = i_cfg_data;
                    hltm_pkg::CFG_TOKEN_LEN:  tok_len = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                items_taken++;
                track_header_byte(i_value_byte, i_last_byte);
            end
            if (o_out_valid && !i_out_stall) begin
                if (found_owed.size() == 0) begin
                    report($sformatf("result transfer with found=%b but none owed",
                                     o_token_found));
                end else begin
                    want = found_owed.pop_front();
                    if (o_token_found !== want)
                        report($sformatf("token_found %b, expected %b (value %0d)",
                                         o_token_found, want, n_hits + n_misses
                                         - found_owed.size()));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed values: case folding, leading separators, trailing blanks, and
        // the zero and all-ones bytes as element content.
        plan_text("gzip");
        plan_len = 4;
        program_token();
        add_text("gZiP");
        flush_value();
        add_text(",\tGZIP ");
        flush_value();
        value_bytes.push_back(8'h00);
        value_bytes.push_back(8'hFF);
        flush_value();
        wait_idle();

        // An element that fills the whole token store and runs one byte past it.
        plan_text("0123456789abcdef");
        plan_len = 16;
        program_token();
        add_text("0123456789ABCDEF0");
        flush_value();
        wait_idle();

        plan_text("gzip");
        plan_len = 4;
        program_token();
        random_phase(150, 30, 30, 1'b0);

        // Zero length never matches, even against a copy of the token bytes.
        plan_text("br");
        plan_len = 0;
        program_token();
        random_phase(100, 20, 20, 1'b0);

        for (int i = 0; i < 16; i++) plan_tok[i] = 8'h61 + 8'($urandom_range(25));
        shape_len = 16;
        plan_len = 16;
        program_token();
        random_phase(150, 0, 0, 1'b0);

        plan_text("x");
        plan_len = 1;
        program_token();
        random_phase(120, 40, 10, 1'b0);

        for (int i = 0; i < 16; i++) plan_tok[i] = 8'hFF;
        shape_len = 8;
        plan_len = 8;
        program_token();
        random_phase(120, 10, 40, 1'b0);

        for (int i = 0; i < 16; i++) plan_tok[i] = 8'h00;
        shape_len = 3;
        plan_len = 3;
        program_token();
        random_phase(100, 20, 20, 1'b0);

        // Lengths beyond the store never match.
        for (int i = 0; i < 16; i++) plan_tok[i] = 8'h61 + 8'($urandom_range(25));
        shape_len = 16;
        plan_len = 17;
        program_token();
        random_phase(80, 20, 20, 1'b0);
        plan_len = 31;
        program_token();
        random_phase(60, 20, 20, 1'b0);

        plan_text("KEEP-ALIVE");
        plan_len = 10;
        program_token();
        random_phase(150, 0, 20, 1'b1);

        for (int i = 0; i < 16; i++) plan_tok[i] = 8'($urandom);
        plan_len = $urandom_range(16, 1);
        shape_len = plan_len;
        program_token();
        random_phase(200, 25, 25, 1'b0);

        $display("Scanned %0d header values (%0d bytes): %0d with the token, %0d without.",
                 values_sent, items_taken, n_hits, n_misses);
        $display("Token settings: %0d, register writes: %0d, long sink hold-offs: %0d.",
                 settings_used, reg_writes, long_holds_done);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/hltm_pkg.sv
rtl/hltm_scan.sv
rtl/header_list_token_match.sv
sim/tb_header_list_token_match.sv
